// ===== src/abbt_pkg.sv =====
`timescale 1ns / 1ps

package abbt_pkg;

   localparam int DEFAULT_MAX_DIM = 4096;

   localparam int COORD_W  = 12;
   localparam int ALPHA_W  = 8;
   localparam int THRESH_W = 9;
   localparam int DIM_W    = 13;
   localparam int CSR_W    = DIM_W;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd1;
   localparam logic [DIM_W-1:0]    DIM_RESET    = 13'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ALPHA_THRESHOLD = 2'd0,
      REG_IMAGE_WIDTH     = 2'd1,
      REG_IMAGE_HEIGHT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
      logic               found;
   } box_type;

endpackage

// ===== src/alpha_bounding_box_trim_top.sv =====
`timescale 1ns / 1ps
// channel   dir  tdata fields (low bit up)                          tlast/tuser
// req_      in   pixel_alpha[7:0]                                   none
// rsp_      out  box_left, box_top, box_right, box_bottom, found    none
// csr_      in   write enable, index 0..2, 13-bit data              none
//
// one pixel per cycle unless the input stalls as below; a frame result passes
// through the input register, then the result register, before it is valid
// reset clears the counters, trackers and output valid, and loads default registers
// the input stalls only when a frame's last pixel meets an unread result

module alpha_bounding_box_trim_top #(
   parameter int MAX_DIM = abbt_pkg::DEFAULT_MAX_DIM
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [abbt_pkg::REQ_DATA_W-1:0] req_tdata,  // pixel_alpha[7:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // box_left[11:0], box_top[23:12], box_right[35:24], box_bottom[47:36],
   // found_opaque[48], zero fill [55:49]
   output logic [abbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [abbt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [abbt_pkg::CSR_W-1:0]      csr_wdata
);
   import abbt_pkg::*;

   localparam int CW = $clog2(MAX_DIM);

   // config registers
   logic [THRESH_W-1:0] thresh_ff;
   logic [DIM_W-1:0]    width_ff, height_ff;

   // input stage
   logic               s1_valid_ff, s1_valid_in;
   logic [ALPHA_W-1:0] s1_alpha_ff, s1_alpha_in;

   // frame trackers
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [CW-1:0] min_col_ff, min_col_in, max_col_ff, max_col_in;
   logic [CW-1:0] min_row_ff, min_row_in, max_row_ff, max_row_in;
   logic          hit_any_ff, hit_any_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   box_type rsp_box_ff, rsp_box_in;

   logic [CW:0]   w_info, h_info;
   logic [CW-1:0] w_last, h_last;
   logic          w_odd, h_odd;
   logic          hit, row_end, frame_end, out_free, s1_fire;
   logic [CW-1:0] hmin_col, hmax_col, hmin_row, hmax_row;
   logic          hhit_any;
   box_type       box_done;

   // clamp a dimension register to 1..MAX_DIM; returns {odd, dim - 1}
   function automatic logic [CW:0] dim_info(input logic [DIM_W-1:0] d);
      logic [CW:0] r;
      if (d == '0) begin
         r = {1'b1, CW'(0)};
      end else if (32'(d) > 32'(MAX_DIM)) begin
         r = {1'(MAX_DIM % 2), CW'(MAX_DIM - 1)};
      end else begin
         r = {d[0], CW'(d - DIM_W'(1))};
      end
      return r;
   endfunction

   assign w_info = dim_info(width_ff);
   assign h_info = dim_info(height_ff);
   assign w_last = w_info[CW-1:0];
   assign h_last = h_info[CW-1:0];
   assign w_odd  = w_info[CW];
   assign h_odd  = h_info[CW];

   assign hit       = {1'b0, s1_alpha_ff} >= thresh_ff;
   assign row_end   = col_ff >= w_last;
   assign frame_end = row_end && (row_ff >= h_last);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign s1_fire   = s1_valid_ff && (!frame_end || out_free);
   assign req_tready = !s1_valid_ff || s1_fire;

   // trackers including the pixel in the input stage
   always_comb begin
      hmin_col = min_col_ff;
      hmax_col = max_col_ff;
      hmin_row = min_row_ff;
      hmax_row = max_row_ff;
      hhit_any = hit_any_ff;
      if (hit) begin
         hhit_any = 1'b1;
         if (!hit_any_ff || col_ff < min_col_ff) hmin_col = col_ff;
         if (!hit_any_ff || col_ff > max_col_ff) hmax_col = col_ff;
         if (!hit_any_ff || row_ff < min_row_ff) hmin_row = row_ff;
         if (!hit_any_ff || row_ff > max_row_ff) hmax_row = row_ff;
      end
   end

   abbt_box_finish #(
      .MAX_DIM (MAX_DIM)
   ) u_finish (
      .min_col    (hmin_col),
      .max_col    (hmax_col),
      .min_row    (hmin_row),
      .max_row    (hmax_row),
      .any_hit    (hhit_any),
      .width_odd  (w_odd),
      .height_odd (h_odd),
      .box        (box_done)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_alpha_in = s1_alpha_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_alpha_in = req_tdata[ALPHA_W-1:0];
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      min_col_in = min_col_ff;
      max_col_in = max_col_ff;
      min_row_in = min_row_ff;
      max_row_in = max_row_ff;
      hit_any_in = hit_any_ff;
      if (s1_fire) begin
         if (frame_end) begin
            col_in     = '0;
            row_in     = '0;
            min_col_in = '1;
            max_col_in = '0;
            min_row_in = '1;
            max_row_in = '0;
            hit_any_in = 1'b0;
         end else begin
            min_col_in = hmin_col;
            max_col_in = hmax_col;
            min_row_in = hmin_row;
            max_row_in = hmax_row;
            hit_any_in = hhit_any;
            if (row_end) begin
               col_in = '0;
               row_in = row_ff + CW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_box_in   = rsp_box_ff;
      if (s1_fire && frame_end) begin
         rsp_valid_in = 1'b1;
         rsp_box_in   = box_done;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_ALPHA_THRESHOLD: thresh_ff <= csr_wdata[THRESH_W-1:0];
            REG_IMAGE_WIDTH:     width_ff  <= csr_wdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT:    height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         min_col_ff   <= '1;
         max_col_ff   <= '0;
         min_row_ff   <= '1;
         max_row_ff   <= '0;
         hit_any_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         min_col_ff   <= min_col_in;
         max_col_ff   <= max_col_in;
         min_row_ff   <= min_row_in;
         max_row_ff   <= max_row_in;
         hit_any_ff   <= hit_any_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_alpha_ff <= s1_alpha_in;
      rsp_box_ff  <= rsp_box_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_box_ff.found, rsp_box_ff.bottom, rsp_box_ff.right,
                        rsp_box_ff.top, rsp_box_ff.left};

endmodule

// ===== src/abbt_box_finish.sv =====
`timescale 1ns / 1ps

module abbt_box_finish #(
   parameter int MAX_DIM = abbt_pkg::DEFAULT_MAX_DIM
) (
   input  logic [$clog2(MAX_DIM)-1:0] min_col,
   input  logic [$clog2(MAX_DIM)-1:0] max_col,
   input  logic [$clog2(MAX_DIM)-1:0] min_row,
   input  logic [$clog2(MAX_DIM)-1:0] max_row,
   input  logic                       any_hit,
   input  logic                       width_odd,
   input  logic                       height_odd,
   output abbt_pkg::box_type          box
);
   import abbt_pkg::*;

   localparam int CW = $clog2(MAX_DIM);
   localparam int XW = (CW + 1 > COORD_W) ? CW + 1 : COORD_W;

   logic [XW-1:0] l_x, r_x, t_x, b_x;
   logic [XW-1:0] l_fix, r_fix, t_fix, b_fix;
   logic          w_mismatch, h_mismatch;

   assign l_x = XW'(min_col);
   assign r_x = XW'(max_col);
   assign t_x = XW'(min_row);
   assign b_x = XW'(max_row);

   // parity of (right - left + 1) is left[0] ^ right[0] ^ 1
   assign w_mismatch = (~(min_col[0] ^ max_col[0])) != width_odd;
   assign h_mismatch = (~(min_row[0] ^ max_row[0])) != height_odd;

   always_comb begin
      l_fix = l_x;
      r_fix = r_x;
      t_fix = t_x;
      b_fix = b_x;
      if (w_mismatch) begin
         if (min_col != '0) begin
            l_fix = l_x - XW'(1);
         end else begin
            r_fix = r_x + XW'(1);
         end
      end
      if (h_mismatch) begin
         if (min_row != '0) begin
            t_fix = t_x - XW'(1);
         end else begin
            b_fix = b_x + XW'(1);
         end
      end
   end

   always_comb begin
      if (any_hit) begin
         box.left   = l_fix[COORD_W-1:0];
         box.top    = t_fix[COORD_W-1:0];
         box.right  = r_fix[COORD_W-1:0];
         box.bottom = b_fix[COORD_W-1:0];
         box.found  = 1'b1;
      end else begin
         // nothing opaque: 2x2 box at the origin
         box.left   = '0;
         box.top    = '0;
         box.right  = COORD_W'(1);
         box.bottom = COORD_W'(1);
         box.found  = 1'b0;
      end
   end

endmodule
